// ----- rtl/euler_to_quaternion_zyx_unit_defines.svh -----
// Assertion macros used by the Euler to quaternion RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef EULER_TO_QUATERNION_ZYX_UNIT_DEFINES_SVH
`define EULER_TO_QUATERNION_ZYX_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define E2Q_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define E2Q_ASSERT(lbl, prop, msg)
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/e2q_pkg.sv -----
// Types, constants and the CORDIC angle table for the Euler to quaternion unit.
// No dependencies.
package e2q_pkg;

	localparam int unsigned ANGLE_BITS    = 16;
	localparam int unsigned OUT_FRAC_BITS = 14;
	localparam int unsigned OUT_W         = OUT_FRAC_BITS + 2;
	localparam int unsigned IN_W          = 16;
	localparam int unsigned CORDIC_STEPS  = 32;
	localparam int unsigned CW            = 34;
	localparam int unsigned PW            = 2 * CW;
	localparam int unsigned SUM_W         = PW + 1;
	localparam int unsigned LANES         = 3;
	localparam int unsigned LANE_X        = 0;
	localparam int unsigned LANE_Y        = 1;
	localparam int unsigned LANE_Z        = 2;
	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

	typedef struct packed {
		logic signed [IN_W-1:0] angle_x;
		logic signed [IN_W-1:0] angle_y;
		logic signed [IN_W-1:0] angle_z;
	} angles_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] quat_w;
		logic signed [OUT_W-1:0] quat_x;
		logic signed [OUT_W-1:0] quat_y;
		logic signed [OUT_W-1:0] quat_z;
	} quat_t;

	// One rotation in flight: x ends as cosine, y as sine, z is the residual angle.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} lane_t;

	typedef lane_t [LANES-1:0] lanes_t;

	// atan(2^-i) in units of 2^32 per turn.
	function automatic logic signed [CW-1:0] atan_turn(input int unsigned i);
		logic [31:0] v;
		unique case (i)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051E;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			24: v = 32'h00000029;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000003;
			29: v = 32'h00000001;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return $signed({{(CW-32){1'b0}}, v});
	endfunction

endpackage

// ----- rtl/e2q_rot_stage.sv -----
// One CORDIC rotation step applied to all three angle lanes, registered.
// Depends on e2q_pkg.
module e2q_rot_stage #(
	parameter int unsigned STEP = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  e2q_pkg::lanes_t lanes_in,
	output logic            valid_out,
	output e2q_pkg::lanes_t lanes_out
);
	import e2q_pkg::*;

	localparam logic signed [CW-1:0] ATAN = atan_turn(STEP);

	lanes_t lanes_next;
	lanes_t lanes_s1;
	logic   valid_s1;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if (!lanes_in[k].z[CW-1]) begin
				lanes_next[k].x = lanes_in[k].x - (lanes_in[k].y >>> STEP);
				lanes_next[k].y = lanes_in[k].y + (lanes_in[k].x >>> STEP);
				lanes_next[k].z = lanes_in[k].z - ATAN;
			end else begin
				lanes_next[k].x = lanes_in[k].x + (lanes_in[k].y >>> STEP);
				lanes_next[k].y = lanes_in[k].y - (lanes_in[k].x >>> STEP);
				lanes_next[k].z = lanes_in[k].z + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_s1 <= lanes_next;
		end
	end

	assign valid_out = valid_s1;
	assign lanes_out = lanes_s1;

endmodule

// ----- rtl/e2q_triple.sv -----
// Triple products of the half-angle sines and cosines, sums, rounding, saturation.
// Five register stages. Depends on e2q_pkg.
module e2q_triple (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  e2q_pkg::lanes_t lanes_in,
	output logic            valid_out,
	output e2q_pkg::quat_t  quat_out
);
	import e2q_pkg::*;

	localparam int unsigned SH   = 60 - OUT_FRAC_BITS;
	localparam int unsigned RW   = SUM_W - SH;
	localparam logic signed [PW-1:0]    RND_AB  = PW'(64'd1 << 29);
	localparam logic signed [SUM_W-1:0] RND_OUT = SUM_W'(72'd1 << (SH - 1));
	localparam logic signed [RW-1:0]    LIM     = RW'(64'd1 << OUT_FRAC_BITS);

	// Pair products, ordered cc, ss, sc, cs (x angle first, y angle second).
	logic signed [PW-1:0]    pair_s1 [4];
	logic signed [CW-1:0]    cz_s1, sz_s1, cz_s2, sz_s2;
	logic signed [CW-1:0]    pair_s2 [4];
	logic signed [PW-1:0]    term_s3 [8];
	logic signed [SUM_W-1:0] sum_s4  [4];
	quat_t                   quat_s5;
	logic [4:0]              valid_s;

	logic signed [PW-1:0]    pair_rnd [4];
	logic signed [SUM_W-1:0] sum_rnd  [4];
	logic signed [RW-1:0]    q_rnd    [4];
	logic signed [OUT_W-1:0] q_sat    [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pair_rnd[k] = pair_s1[k] + RND_AB;
			sum_rnd[k]  = sum_s4[k] + RND_OUT;
			q_rnd[k]    = sum_rnd[k][SH +: RW];
			if (q_rnd[k] > LIM) begin
				q_sat[k] = LIM[OUT_W-1:0];
			end else if (q_rnd[k] < -LIM) begin
				q_sat[k] = OUT_W'(-LIM);
			end else begin
				q_sat[k] = q_rnd[k][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[3:0], valid_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1[0] <= lanes_in[LANE_X].x * lanes_in[LANE_Y].x;
			pair_s1[1] <= lanes_in[LANE_X].y * lanes_in[LANE_Y].y;
			pair_s1[2] <= lanes_in[LANE_X].y * lanes_in[LANE_Y].x;
			pair_s1[3] <= lanes_in[LANE_X].x * lanes_in[LANE_Y].y;
			cz_s1      <= lanes_in[LANE_Z].x;
			sz_s1      <= lanes_in[LANE_Z].y;

			for (int k = 0; k < 4; k++) begin
				pair_s2[k] <= pair_rnd[k][30 +: CW];
			end
			cz_s2 <= cz_s1;
			sz_s2 <= sz_s1;

			term_s3[0] <= pair_s2[0] * cz_s2;
			term_s3[1] <= pair_s2[1] * sz_s2;
			term_s3[2] <= pair_s2[2] * cz_s2;
			term_s3[3] <= pair_s2[3] * sz_s2;
			term_s3[4] <= pair_s2[3] * cz_s2;
			term_s3[5] <= pair_s2[2] * sz_s2;
			term_s3[6] <= pair_s2[0] * sz_s2;
			term_s3[7] <= pair_s2[1] * cz_s2;

			sum_s4[0] <= SUM_W'(term_s3[0]) + SUM_W'(term_s3[1]);
			sum_s4[1] <= SUM_W'(term_s3[2]) - SUM_W'(term_s3[3]);
			sum_s4[2] <= SUM_W'(term_s3[4]) + SUM_W'(term_s3[5]);
			sum_s4[3] <= SUM_W'(term_s3[6]) - SUM_W'(term_s3[7]);

			quat_s5.quat_w <= q_sat[0];
			quat_s5.quat_x <= q_sat[1];
			quat_s5.quat_y <= q_sat[2];
			quat_s5.quat_z <= q_sat[3];
		end
	end

	assign valid_out = valid_s[4];
	assign quat_out  = quat_s5;

endmodule

// ----- rtl/e2q_skid.sv -----
// Output register with one skid entry; decides when the pipeline may advance.
// Depends on e2q_pkg and the assertion macro header.
`include "euler_to_quaternion_zyx_unit_defines.svh"
module e2q_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  e2q_pkg::quat_t item,
	output logic           pipe_en,
	output logic           quat_valid,
	input  logic           quat_stall,
	output e2q_pkg::quat_t quat
);
	import e2q_pkg::*;

	quat_t out_q, skid_q;
	logic  out_valid_q, skid_valid_q;
	logic  leave, free;

	assign pipe_en = !skid_valid_q;
	assign leave   = item_valid && pipe_en;
	assign free    = !out_valid_q || !quat_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q  <= skid_valid_q || leave;
			skid_valid_q <= 1'b0;
		end else if (leave) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			out_q <= skid_valid_q ? skid_q : item;
		end else if (leave) begin
			skid_q <= item;
		end
	end

	assign quat_valid = out_valid_q;
	assign quat       = out_q;

	`E2Q_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid entry without output")
	`E2Q_ASSERT_NEXT(a_skid_fill, out_valid_q && quat_stall && leave, skid_valid_q, "item lost")
	`E2Q_ASSERT_NEXT(a_skid_drain, skid_valid_q && !quat_stall, !skid_valid_q, "skid stuck")

endmodule

// ----- rtl/euler_to_quaternion_zyx_unit.sv -----
// Top level of the Euler to quaternion unit.
// Depends on e2q_pkg, e2q_rot_stage, e2q_triple and e2q_skid.
//
// Converts three signed binary angles (a full turn is 65536) into the unit
// quaternion q = qZ * qY * qX for Tait-Bryan ZYX order, as four signed Q1.14
// components saturated to plus or minus 1.0. The unit takes one transaction
// every cycle while the input is not stalled. Each accepted transaction
// passes through the pipelined CORDIC, one rotation step per register stage
// for all three angles side by side, then the registers for the pair
// products, triple products, sums and rounding, and then the output
// register. When the consumer stalls, one more transaction is caught in a
// skid entry, after which the input is stalled until the output drains.
module euler_to_quaternion_zyx_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            angles_valid,
	output logic            angles_stall,
	input  e2q_pkg::angles_t angles,
	output logic            quat_valid,
	input  logic            quat_stall,
	output e2q_pkg::quat_t  quat
);
	import e2q_pkg::*;

	lanes_t lanes_c [CORDIC_STEPS+1];
	logic   valid_c [CORDIC_STEPS+1];
	lanes_t lanes_entry;
	logic   pipe_en;
	logic   prod_valid;
	quat_t  prod_quat;

	// Each angle is halved on entry: the low ANGLE_BITS bits become a signed
	// half angle in a 2^32-per-turn scale. Bits above ANGLE_BITS are ignored.
	always_comb begin
		lanes_entry[LANE_X].z = CW'($signed(angles.angle_x[ANGLE_BITS-1:0])) <<< (31 - ANGLE_BITS);
		lanes_entry[LANE_Y].z = CW'($signed(angles.angle_y[ANGLE_BITS-1:0])) <<< (31 - ANGLE_BITS);
		lanes_entry[LANE_Z].z = CW'($signed(angles.angle_z[ANGLE_BITS-1:0])) <<< (31 - ANGLE_BITS);
		for (int k = 0; k < LANES; k++) begin
			lanes_entry[k].x = CORDIC_GAIN;
			lanes_entry[k].y = '0;
		end
	end

	assign lanes_c[0] = lanes_entry;

	// The first stage only loads while the pipeline advances, and then the
	// input is not stalled, so valid alone marks an accepted transaction.
	assign valid_c[0]   = angles_valid;
	assign angles_stall = !pipe_en;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		e2q_rot_stage #(
			.STEP(i)
		) u_rot (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pipe_en),
			.valid_in (valid_c[i]),
			.lanes_in (lanes_c[i]),
			.valid_out(valid_c[i+1]),
			.lanes_out(lanes_c[i+1])
		);
	end

	e2q_triple u_triple (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.valid_in (valid_c[CORDIC_STEPS]),
		.lanes_in (lanes_c[CORDIC_STEPS]),
		.valid_out(prod_valid),
		.quat_out (prod_quat)
	);

	e2q_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(prod_valid),
		.item      (prod_quat),
		.pipe_en   (pipe_en),
		.quat_valid(quat_valid),
		.quat_stall(quat_stall),
		.quat      (quat)
	);

endmodule
